/* rtl/fss_pkg.sv */
// Package for the fuzzy subsequence scorer: operation and field codes,
// score constants and the character class helpers. No dependencies.
package fss_pkg;

  localparam int unsigned MAX_PATTERN = 32;
  localparam int unsigned SLOT_W      = $clog2(MAX_PATTERN);
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned SCORE_W     = 12;
  localparam int unsigned OUT_W       = 13;
  localparam int unsigned RUN_W       = 6;
  localparam int unsigned TLEN_W      = 8;
  localparam int unsigned INC_W       = 9;

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
  localparam logic [OUT_W-1:0]   OUT_MAX   = '1;

  localparam logic [INC_W-1:0] BOUNDARY_BONUS = INC_W'(10);
  localparam logic [INC_W-1:0] START_BONUS    = INC_W'(8);
  localparam logic [4:0]       SHORT_BONUS    = 5'd15;

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TEXT = 2'd1,
    OP_END  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_NAME     = 2'd0,
    KIND_GENERIC  = 2'd1,
    KIND_KEYWORD  = 2'd2,
    KIND_CATEGORY = 2'd3
  } kind_t;

  typedef enum logic {
    REG_PATTERN_LENGTH = 1'b0,
    REG_ENTRY_MODE     = 1'b1
  } reg_index_t;

  function automatic logic is_low(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_up(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return is_up(c) ? (c + 8'd32) : c;
  endfunction

endpackage

/* rtl/fss_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone, no package dependency.
module fss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/fuzzy_subsequence_scorer_core.sv */
// Top level of the fuzzy subsequence scorer: greedy case-insensitive matcher
// with entry aggregation. Depends on fss_pkg and fss_ram.
//
//   channel  | direction | handshake          | contents
//   s_       | in        | s_tvalid/s_tready  | tdata: pattern_slot, ch; tuser: op, field_kind;
//            |           |                    | tlast: end_of_field
//   m_       | out       | m_tvalid/m_tready  | tdata: match_score
//   cfg_     | in        | cfg_we             | cfg_index selects register, cfg_wdata value
//
// One request is taken every cycle while s_tready is high; a result appears in the
// cycle after the request that causes it. The pattern RAM is read one position ahead,
// so the next pattern byte is already on its output when the following text byte
// arrives. Writes to the slot being fetched are forwarded. The input stalls
// only while a result waits in the output register and m_tready is low.
// Reset is synchronous and needs no clearing pass; the pattern RAM is not reset.
module fuzzy_subsequence_scorer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [4:0] pattern_slot, [12:5] ch, [15:13] zero
  input  logic [3:0]  s_tuser,   // [1:0] op, [3:2] field_kind
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [12:0] match_score, [15:13] zero
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_wdata
);

  localparam int unsigned SW = fss_pkg::SLOT_W;
  localparam int unsigned LW = fss_pkg::LEN_W;
  localparam int unsigned CW = fss_pkg::SCORE_W;
  localparam int unsigned OW = fss_pkg::OUT_W;
  localparam int unsigned RW = fss_pkg::RUN_W;
  localparam int unsigned TW = fss_pkg::TLEN_W;
  localparam int unsigned IW = fss_pkg::INC_W;

  // Request fields
  logic [SW-1:0]      slot;
  logic [7:0]         ch;
  fss_pkg::op_t       op;
  fss_pkg::kind_t     kind;
  logic               accept;

  // Configuration
  logic [LW-1:0] pattern_length;
  logic          entry_mode;
  logic [LW-1:0] plen;

  // String state
  logic [LW-1:0] pattern_pos, pattern_pos_next;
  logic [RW-1:0] run_length, run_length_next;
  logic [CW-1:0] running_score, running_score_next;
  logic [7:0]    prev_char, prev_char_next;
  logic [TW-1:0] text_length, text_length_next;

  // Entry bests
  logic [OW-1:0] name_best, name_best_next;
  logic [OW-1:0] generic_best, generic_best_next;
  logic [CW-1:0] keyword_best, keyword_best_next;
  logic [CW-1:0] category_best, category_best_next;

  // Pattern RAM and forwarding
  logic          ram_we;
  logic [SW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          fwd_hit;
  logic [7:0]    fwd_data;
  logic [7:0]    pchar;

  // Feed datapath
  logic          is_kw;
  logic          is_semi;
  logic          do_feed;
  logic          matched;
  logic          start;
  logic          boundary;
  logic [IW-1:0] inc;
  logic [CW:0]   score_sum;
  logic [LW-1:0] f_pos;
  logic [RW-1:0] f_run;
  logic [CW-1:0] f_score;
  logic [TW-1:0] f_tl;
  logic [CW:0]   fin_sum;
  logic [CW-1:0] fin;
  logic [OW:0]   fin_x3;
  logic [OW-1:0] w3;
  logic [OW-1:0] w2;
  logic          clear_str;
  logic          seg_fold;
  logic [OW-1:0] entry_max;

  // Result
  logic          res_valid;
  logic [OW-1:0] res_score;
  logic [OW-1:0] match_score;

  assign slot     = s_tdata[SW-1:0];
  assign ch       = s_tdata[SW+7:SW];
  assign op       = fss_pkg::op_t'(s_tuser[1:0]);
  assign kind     = fss_pkg::kind_t'(s_tuser[3:2]);
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign plen = (pattern_length > LW'(fss_pkg::MAX_PATTERN)) ?
                LW'(fss_pkg::MAX_PATTERN) : pattern_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      entry_mode     <= 1'b0;
    end else if (cfg_we) begin
      unique case (fss_pkg::reg_index_t'(cfg_index))
        fss_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_wdata[LW-1:0];
        fss_pkg::REG_ENTRY_MODE:     entry_mode     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // The RAM is addressed with the position the string will have next cycle.
  assign ram_we    = accept && (op == fss_pkg::OP_LOAD) &&
                     ({1'b0, slot} < (SW + 1)'(fss_pkg::MAX_PATTERN));
  assign ram_raddr = rst ? '0 : pattern_pos_next[SW-1:0];

  fss_ram #(
    .WIDTH(8),
    .DEPTH(fss_pkg::MAX_PATTERN)
  ) u_pattern_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (ch),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= ram_we && (slot == ram_raddr);
    end
    fwd_data <= ch;
  end

  assign pchar = fwd_hit ? fwd_data : ram_rdata;

  always_comb begin
    is_kw   = (kind == fss_pkg::KIND_KEYWORD) || (kind == fss_pkg::KIND_CATEGORY);
    is_semi = (ch == fss_pkg::CH_SEMI);
    do_feed = accept && (op == fss_pkg::OP_TEXT) && !(entry_mode && is_kw && is_semi);
    matched = (pattern_pos < plen) && (fss_pkg::fold(ch) == fss_pkg::fold(pchar));
    start   = (text_length == '0);
    boundary = start || (prev_char == fss_pkg::CH_SPACE) ||
               (prev_char == fss_pkg::CH_DASH) || (prev_char == fss_pkg::CH_UNDER) ||
               (prev_char == fss_pkg::CH_DOT) ||
               (fss_pkg::is_low(prev_char) && fss_pkg::is_up(ch));
    inc = IW'(1) + (boundary ? fss_pkg::BOUNDARY_BONUS : '0) +
          {1'b0, run_length, 2'b00} + (start ? fss_pkg::START_BONUS : '0) +
          IW'(ch == pchar);
    score_sum = {1'b0, running_score} + (CW + 1)'(inc);

    f_pos   = pattern_pos;
    f_run   = run_length;
    f_score = running_score;
    f_tl    = text_length;
    if (do_feed) begin
      f_tl = (text_length == '1) ? text_length : text_length + TW'(1);
      if (matched) begin
        f_score = score_sum[CW] ? fss_pkg::SCORE_MAX : score_sum[CW-1:0];
        f_run   = (run_length == '1) ? run_length : run_length + RW'(1);
        f_pos   = pattern_pos + LW'(1);
      end else if (pattern_pos < plen) begin
        f_run = '0;
      end
    end

    // Score of the string as it stands after this byte.
    fin_sum = {1'b0, f_score} +
              (({1'b0, f_tl} <= ((TW + 1)'(plen) + (TW + 1)'(2))) ?
               (CW + 1)'(fss_pkg::SHORT_BONUS) : '0);
    if (plen == '0) begin
      fin = CW'(1);
    end else if ((f_tl == '0) || (f_pos < plen)) begin
      fin = '0;
    end else begin
      fin = fin_sum[CW] ? fss_pkg::SCORE_MAX : fin_sum[CW-1:0];
    end
    fin_x3 = (OW + 1)'({fin, 1'b0}) + (OW + 1)'(fin);
    w3 = (fin_x3 > (OW + 1)'(fss_pkg::OUT_MAX)) ? fss_pkg::OUT_MAX : fin_x3[OW-1:0];
    w2 = {fin, 1'b0};

    clear_str = accept && ((op == fss_pkg::OP_END) ||
                ((op == fss_pkg::OP_TEXT) && (s_tlast || (entry_mode && is_kw && is_semi))));
    seg_fold  = accept && (op == fss_pkg::OP_TEXT) && entry_mode && is_kw &&
                (is_semi || s_tlast) && (f_tl != '0);

    entry_max = name_best;
    if (generic_best > entry_max) entry_max = generic_best;
    if (OW'(keyword_best) > entry_max) entry_max = OW'(keyword_best);
    if (OW'(category_best) > entry_max) entry_max = OW'(category_best);
  end

  always_comb begin
    if (clear_str) begin
      pattern_pos_next   = '0;
      run_length_next    = '0;
      running_score_next = '0;
      prev_char_next     = '0;
      text_length_next   = '0;
    end else begin
      pattern_pos_next   = f_pos;
      run_length_next    = f_run;
      running_score_next = f_score;
      prev_char_next     = do_feed ? ch : prev_char;
      text_length_next   = f_tl;
    end

    name_best_next     = name_best;
    generic_best_next  = generic_best;
    keyword_best_next  = keyword_best;
    category_best_next = category_best;
    res_valid          = 1'b0;
    res_score          = '0;

    if (accept) begin
      unique case (op)
        fss_pkg::OP_TEXT: begin
          if (!entry_mode) begin
            res_valid = s_tlast;
            res_score = OW'(fin);
          end else if (seg_fold) begin
            if (kind == fss_pkg::KIND_KEYWORD) begin
              if (fin > keyword_best) keyword_best_next = fin;
            end else begin
              if (fin > category_best) category_best_next = fin;
            end
          end else if (s_tlast && !is_kw) begin
            if (kind == fss_pkg::KIND_NAME) begin
              if (w3 > name_best) name_best_next = w3;
            end else begin
              if (w2 > generic_best) generic_best_next = w2;
            end
          end
        end
        fss_pkg::OP_END: begin
          res_valid = 1'b1;
          if (plen == '0) begin
            res_score = OW'(1);
          end else if (!entry_mode) begin
            res_score = '0;
          end else begin
            res_score = entry_max;
          end
          name_best_next     = '0;
          generic_best_next  = '0;
          keyword_best_next  = '0;
          category_best_next = '0;
        end
        fss_pkg::OP_LOAD, fss_pkg::OP_NONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_pos   <= '0;
      run_length    <= '0;
      running_score <= '0;
      prev_char     <= '0;
      text_length   <= '0;
      name_best     <= '0;
      generic_best  <= '0;
      keyword_best  <= '0;
      category_best <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      pattern_pos   <= pattern_pos_next;
      run_length    <= run_length_next;
      running_score <= running_score_next;
      prev_char     <= prev_char_next;
      text_length   <= text_length_next;
      name_best     <= name_best_next;
      generic_best  <= generic_best_next;
      keyword_best  <= keyword_best_next;
      category_best <= category_best_next;
      if (res_valid) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      match_score <= res_score;
    end
  end

  assign m_tdata = {3'b000, match_score};

endmodule

/* rtl/fss_checker.sv */
// Port-level checks for the fuzzy subsequence scorer, bound to the top level.
// Depends on fss_pkg for the operation codes.
module fss_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [3:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // A request ending an entry always leaves a result behind.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[1:0] == fss_pkg::OP_END) |=> m_tvalid)
    else $error("end-of-entry request gave no result");

  // Loading a pattern byte never creates a result.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[1:0] == fss_pkg::OP_LOAD) && !m_tvalid |=> !m_tvalid)
    else $error("pattern load produced a result");

  // With the output register empty the input side must not stall.
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  // A held result keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result present after reset");

endmodule

bind fuzzy_subsequence_scorer_core fss_checker u_fss_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* tb/tb_fuzzy_subsequence_scorer_core.sv */
// Self-checking testbench for fuzzy_subsequence_scorer_core: directed and random
// pattern, string and entry traffic checked against a scoring model kept in step.
// Depends on fss_pkg and the scorer RTL.
module tb_fuzzy_subsequence_scorer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import fss_pkg::*;

  localparam int unsigned PHASES          = 12;
  localparam int unsigned ITEMS_PER_PHASE = 125;
  localparam int unsigned HOLD_CYCLES     = 400;

  typedef struct {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        ch;
    kind_t             kind;
    logic              last;
  } scorer_req_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata   = '0;
  logic [3:0]        s_tuser   = '0;
  logic              s_tlast   = 1'b0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [15:0]       m_tdata;
  logic              cfg_we    = 1'b0;
  logic              cfg_index = REG_PATTERN_LENGTH;
  logic [5:0]        cfg_wdata = '0;

  // Stimulus side.
  scorer_req_t       queued_requests[$];
  scorer_req_t       cur_req = '{OP_NONE, '0, '0, KIND_NAME, 1'b0};
  logic [7:0]        stim_pat [MAX_PATTERN];
  logic [7:0]        text_buf[$];
  int unsigned       stim_len = 0;
  int unsigned       req_count = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       ready_hold_left = 0;
  logic              hold_go = 1'b0;
  logic              hold_done = 1'b0;
  logic              req_taken = 1'b0;

  // Scoring model state.
  logic [7:0]        pat_mem [MAX_PATTERN];
  logic [LEN_W-1:0]  model_plen   = '0;
  logic              model_entry  = 1'b0;
  logic [5:0]        match_pos    = '0;
  logic [RUN_W-1:0]  run_len      = '0;
  logic [SCORE_W-1:0] run_score   = '0;
  logic [7:0]        prev_ch      = '0;
  logic [TLEN_W-1:0] text_len     = '0;
  logic [OUT_W-1:0]  best_name    = '0;
  logic [OUT_W-1:0]  best_generic = '0;
  logic [SCORE_W-1:0] best_keyword  = '0;
  logic [SCORE_W-1:0] best_category = '0;
  logic [OUT_W-1:0]  pending_scores[$];
  int unsigned       fail_count = 0;

  fuzzy_subsequence_scorer_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic logic ascii_upper(logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic ascii_lower(logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic [7:0] lower_case(logic [7:0] c);
    return ascii_upper(c) ? c + 8'd32 : c;
  endfunction

  function automatic int unsigned active_len();
    return (model_plen > MAX_PATTERN) ? MAX_PATTERN : model_plen;
  endfunction

  function automatic void clear_string();
    match_pos = '0;
    run_len   = '0;
    run_score = '0;
    prev_ch   = '0;
    text_len  = '0;
  endfunction

  function automatic void consume_char(logic [7:0] c);
    int unsigned gain;
    logic [7:0]  want;
    logic        at_start;
    logic        boundary;
    if (match_pos < active_len()) begin
      want = pat_mem[match_pos[SLOT_W-1:0]];
      if (lower_case(c) == lower_case(want)) begin
        at_start = (text_len == 0);
        boundary = at_start || prev_ch == CH_SPACE || prev_ch == CH_DASH ||
                   prev_ch == CH_UNDER || prev_ch == CH_DOT ||
                   (ascii_lower(prev_ch) && ascii_upper(c));
        gain = 1 + 4 * run_len;
        if (boundary) gain += BOUNDARY_BONUS;
        if (at_start) gain += START_BONUS;
        if (c == want) gain += 1;
        run_score = (run_score + gain > SCORE_MAX) ? SCORE_MAX :
                    SCORE_W'(run_score + gain);
        if (run_len != '1) run_len++;
        match_pos++;
      end else begin
        run_len = '0;
      end
    end
    prev_ch = c;
    if (text_len != '1) text_len++;
  endfunction

  function automatic int unsigned string_score();
    int unsigned total;
    if (active_len() == 0) return 1;
    if (text_len == 0 || match_pos < active_len()) return 0;
    total = run_score;
    if (text_len <= active_len() + 2) total += SHORT_BONUS;
    return (total > SCORE_MAX) ? SCORE_MAX : total;
  endfunction

  // Applies one accepted request to the model and queues the score it yields.
  function automatic void advance_scoring(scorer_req_t req);
    int unsigned      score;
    logic [OUT_W-1:0] top;
    case (req.op)
      OP_LOAD: pat_mem[req.slot] = req.ch;
      OP_TEXT: begin
        if (!model_entry) begin
          consume_char(req.ch);
          if (req.last) begin
            pending_scores.push_back(OUT_W'(string_score()));
            clear_string();
          end
        end else if (req.kind == KIND_KEYWORD || req.kind == KIND_CATEGORY) begin
          // A semicolon closes a segment and is not part of it.
          if (req.ch != CH_SEMI) consume_char(req.ch);
          if (req.ch == CH_SEMI || req.last) begin
            if (text_len != 0) begin
              score = string_score();
              if (req.kind == KIND_KEYWORD && score > best_keyword)
                best_keyword = SCORE_W'(score);
              if (req.kind == KIND_CATEGORY && score > best_category)
                best_category = SCORE_W'(score);
            end
            clear_string();
          end
        end else begin
          consume_char(req.ch);
          if (req.last) begin
            score = string_score() * ((req.kind == KIND_NAME) ? 3 : 2);
            if (score > OUT_MAX) score = OUT_MAX;
            if (req.kind == KIND_NAME && score > best_name) best_name = OUT_W'(score);
            if (req.kind == KIND_GENERIC && score > best_generic)
              best_generic = OUT_W'(score);
            clear_string();
          end
        end
      end
      OP_END: begin
        clear_string();
        if (active_len() == 0) begin
          top = OUT_W'(1);
        end else if (!model_entry) begin
          top = '0;
        end else begin
          top = best_name;
          if (best_generic > top) top = best_generic;
          if (OUT_W'(best_keyword) > top) top = OUT_W'(best_keyword);
          if (OUT_W'(best_category) > top) top = OUT_W'(best_category);
        end
        pending_scores.push_back(top);
        best_name     = '0;
        best_generic  = '0;
        best_keyword  = '0;
        best_category = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic void log_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void push_req(op_t op, logic [SLOT_W-1:0] slot, logic [7:0] ch,
                                   kind_t kind, logic last);
    queued_requests.push_back('{op, slot, ch, kind, last});
    if (op != OP_NONE) req_count++;
  endfunction

  function automatic void push_end();
    push_req(OP_END, SLOT_W'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
             kind_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
  endfunction

  function automatic logic [7:0] pick_letter();
    logic [7:0] c;
    c = 8'h61 + 8'($urandom_range(0, 25));
    if ($urandom_range(0, 1)) c = c - 8'd32;
    return c;
  endfunction

  function automatic logic [7:0] pick_separator();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_DASH;
      2: return CH_UNDER;
      default: return CH_DOT;
    endcase
  endfunction

  function automatic logic [7:0] pick_pattern_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return pick_letter();
    if (r < 75) return 8'h30 + 8'($urandom_range(0, 9));
    if (r < 85) return pick_separator();
    return 8'($urandom_range(128, 255));
  endfunction

  function automatic logic [7:0] pick_filler();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return pick_letter();
    if (r < 70) return pick_separator();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void load_pattern(int unsigned count);
    for (int i = 0; i < count; i++) begin
      stim_pat[i] = pick_pattern_char();
      push_req(OP_LOAD, SLOT_W'(i), stim_pat[i], kind_t'($urandom_range(0, 3)),
               1'($urandom_range(0, 1)));
    end
  endfunction

  // Text that holds the pattern as a subsequence, with random case and fillers.
  function automatic void append_match();
    for (int i = 0; i < stim_len; i++) begin
      int unsigned gap;
      logic [7:0]  c;
      gap = ($urandom_range(0, 99) < 50) ? 0 : $urandom_range(1, 3);
      repeat (gap) text_buf.push_back(pick_filler());
      c = stim_pat[i];
      if ((ascii_upper(c) || ascii_lower(c)) && $urandom_range(0, 1)) c = c ^ 8'h20;
      text_buf.push_back(c);
    end
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) text_buf.push_back(pick_filler());
  endfunction

  function automatic void append_noise(int unsigned count);
    repeat (count) text_buf.push_back(pick_filler());
  endfunction

  function automatic void append_segments();
    int unsigned segs;
    segs = $urandom_range(1, 4);
    for (int s = 0; s < segs; s++) begin
      if (s != 0) text_buf.push_back(CH_SEMI);
      case ($urandom_range(0, 3))
        0, 1: append_match();
        2: append_noise($urandom_range(1, 5));
        default: ;
      endcase
    end
    if ($urandom_range(0, 3) == 0) text_buf.push_back(CH_SEMI);
  endfunction

  function automatic void send_text(kind_t kind, logic close);
    if (text_buf.size() == 0) text_buf.push_back(pick_letter());
    foreach (text_buf[i])
      push_req(OP_TEXT, SLOT_W'($urandom_range(0, 31)), text_buf[i], kind,
               close && (i == text_buf.size() - 1));
    text_buf.delete();
  endfunction

  function automatic void send_str(string s, kind_t kind, logic close);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_text(kind, close);
  endfunction

  function automatic void gen_noise();
    logic [SLOT_W-1:0] slot;
    logic [7:0]        c;
    case ($urandom_range(0, 2))
      0: push_end();
      1: push_req(OP_NONE, SLOT_W'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                  kind_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      default: begin
        // Rewrite a pattern byte in the middle of the traffic.
        slot = SLOT_W'($urandom_range(0, 31));
        c = pick_pattern_char();
        stim_pat[slot] = c;
        push_req(OP_LOAD, slot, c, kind_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
    endcase
  endfunction

  function automatic void gen_single_case();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      append_match();
      send_text(kind_t'($urandom_range(0, 3)), 1'b1);
    end else if (pick < 82) begin
      append_noise($urandom_range(1, 8));
      send_text(kind_t'($urandom_range(0, 3)), 1'b1);
    end else if (pick < 88) begin
      append_match();
      send_text(kind_t'($urandom_range(0, 3)), 1'b0);
      push_end();
    end else begin
      gen_noise();
    end
  endfunction

  function automatic void gen_entry_case();
    int unsigned pick;
    kind_t       kind;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      repeat ($urandom_range(1, 5)) begin
        kind = kind_t'($urandom_range(0, 3));
        if (kind == KIND_KEYWORD || kind == KIND_CATEGORY) append_segments();
        else if ($urandom_range(0, 99) < 70) append_match();
        else append_noise($urandom_range(1, 6));
        send_text(kind, 1'b1);
      end
      push_end();
    end else if (pick < 85) begin
      append_match();
      send_text(kind_t'($urandom_range(0, 3)), 1'b0);
      push_end();
    end else begin
      gen_noise();
    end
  endfunction

  task automatic write_reg(reg_index_t idx, logic [5:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PATTERN_LENGTH) model_plen = value;
    else model_entry = value[0];
  endtask

  task automatic wait_idle();
    while (queued_requests.size() != 0 || s_tvalid || pending_scores.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // ------------------------------------------------------ driver and monitor

  always @(negedge clk) begin : drive_requests
    logic offer;
    offer = s_tvalid;
    if (!rst) begin
      if (s_tvalid && req_taken) begin
        advance_scoring(cur_req);
        offer = 1'b0;
      end
      if (!offer && queued_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_req = queued_requests.pop_front();
        offer = 1'b1;
      end
    end
    s_tvalid <= offer;
    s_tdata  <= {3'b000, cur_req.ch, cur_req.slot};
    s_tuser  <= {cur_req.kind, cur_req.op};
    s_tlast  <= cur_req.last;
  end

  // The long hold is started once by the sequence and counted down here.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b1;
    end else if (hold_go && !hold_done) begin
      m_tready        <= 1'b0;
      hold_done       <= 1'b1;
      ready_hold_left <= HOLD_CYCLES - 1;
    end else if (ready_hold_left > 0) begin
      m_tready <= 1'b0;
      ready_hold_left <= ready_hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_scores
    logic [OUT_W-1:0] want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        if (pending_scores.size() == 0) begin
          log_failure($sformatf("unexpected score %0d at %0t", m_tdata[OUT_W-1:0], $realtime));
        end else begin
          want = pending_scores.pop_front();
          if (m_tdata[OUT_W-1:0] !== want)
            log_failure($sformatf("score mismatch at %0t: expected %0d, got %0d",
                                  $realtime, want, m_tdata[OUT_W-1:0]));
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : stimulus
    int unsigned plens [PHASES];
    int unsigned phase_start;
    plens = '{1, 3, 2, 5, 4, 8, 6, 0, 32, 63, 12, 45};
    foreach (pat_mem[i]) pat_mem[i] = '0;
    foreach (stim_pat[i]) stim_pat[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Empty pattern: every string and the empty string score 1.
    write_reg(REG_PATTERN_LENGTH, '0);
    write_reg(REG_ENTRY_MODE, '0);
    load_pattern(MAX_PATTERN);
    push_end();
    send_str("q", KIND_NAME, 1'b1);
    wait_idle();

    write_reg(REG_PATTERN_LENGTH, 6'd3);
    begin
      string pat;
      pat = "aBc";
      for (int i = 0; i < 3; i++) begin
        stim_pat[i] = pat[i];
        push_req(OP_LOAD, SLOT_W'(i), pat[i], KIND_NAME, 1'b0);
      end
    end
    send_str("aBc", KIND_NAME, 1'b1);      // start, run and exact case bonuses
    send_str("x_AbC", KIND_GENERIC, 1'b1); // separator and lower-to-upper boundaries
    send_str("axbc", KIND_KEYWORD, 1'b1);  // run broken by a mismatch
    send_str("ab", KIND_NAME, 1'b0);       // unfinished string dropped at end
    push_end();
    text_buf.push_back(8'h00);
    text_buf.push_back(8'hFF);
    send_text(KIND_CATEGORY, 1'b1);
    push_req(OP_NONE, '1, '1, KIND_CATEGORY, 1'b1);
    wait_idle();

    write_reg(REG_ENTRY_MODE, 6'd1);
    send_str("abc", KIND_NAME, 1'b1);
    send_str("z;aBc;", KIND_KEYWORD, 1'b1);
    push_end();
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(REG_PATTERN_LENGTH, LEN_W'(plens[ph]));
      write_reg(REG_ENTRY_MODE, {5'($urandom_range(0, 31)), 1'(ph % 2)});
      stim_len = (plens[ph] > MAX_PATTERN) ? MAX_PATTERN : plens[ph];
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      load_pattern(stim_len);
      phase_start = req_count;
      if (ph == 2) begin
        // Long enough to saturate the text length counter.
        append_noise(280);
        append_match();
        send_text(KIND_NAME, 1'b1);
      end
      while (req_count - phase_start < ITEMS_PER_PHASE) begin
        if (ph % 2) gen_entry_case();
        else gen_single_case();
      end
      if (ph == 0) begin
        // Hold the result side off while requests keep coming.
        @(posedge clk);
        hold_go <= 1'b1;
      end
      wait_idle();
    end

    if (fail_count == 0 && pending_scores.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : run_limit
    #(2_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/fss_pkg.sv
rtl/fss_ram.sv
rtl/fuzzy_subsequence_scorer_core.sv
rtl/fss_checker.sv
tb/tb_fuzzy_subsequence_scorer_core.sv
